@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared constants, types and codes of the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_BITS     = 16;
  localparam int CHANNEL_BITS = 8;

  // Depth of the queue between the classifying front and the arithmetic back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [HUE_BITS-1:0]     hue_t;
  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [2:0]              sector_t;

  // Hue sectors, each one sixth of a turn.
  localparam sector_t SEC_RED_YELLOW    = 3'd0;
  localparam sector_t SEC_YELLOW_GREEN  = 3'd1;
  localparam sector_t SEC_GREEN_CYAN    = 3'd2;
  localparam sector_t SEC_CYAN_BLUE     = 3'd3;
  localparam sector_t SEC_BLUE_MAGENTA  = 3'd4;
  localparam sector_t SEC_MAGENTA_RED   = 3'd5;

  // A classified request as it waits in the queue.
  typedef struct packed {
    sector_t sector;
    hue_t    frac;
    chan_t   sat;
    chan_t   bright;
    logic    gray;
  } hsv_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    chan_t bright;
  } back_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsv_if.sv @@
// Handshake channel that carries one HSV color request.
`timescale 1ns / 1ps
`default_nettype none

interface hsv_if import hsv2rgb_pkg::*; ();
  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_if.sv @@
// Handshake channel that carries one RGB color result.
`timescale 1ns / 1ps
`default_nettype none

interface rgb_if import hsv2rgb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hsv2rgb_front.sv @@
// Front stage: accepts HSV requests and splits the hue into sector and fraction.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hsv_if.sink       hsv,
  input  q_stat_t   qstat,
  output logic      push,
  output hsv_item_t item
);

  logic [HUE_BITS+2:0] hue6;
  logic                full;
  hsv_item_t           held;

  // hue * 6 as two shifted adds; the top three bits are the sector.
  assign hue6 = ({3'b000, hsv.hue} << 2) + ({3'b000, hsv.hue} << 1);

  assign hsv.ready = !full || !qstat.full;
  assign push      = full;
  assign item      = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (hsv.ready) begin
      full <= hsv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hsv.ready) begin
      held.sector <= hue6[HUE_BITS+2:HUE_BITS];
      held.frac   <= hue6[HUE_BITS-1:0];
      held.sat    <= hsv.saturation;
      held.bright <= hsv.brightness;
      held.gray   <= (hsv.saturation == '0);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_queue.sv @@
// Short queue that decouples the front stage from the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_queue import hsv2rgb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hsv_item_t push_item,
  input  logic      pop,
  output logic      out_valid,
  output hsv_item_t out_item,
  output q_stat_t   qstat
);

  hsv_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_ok;
  logic              pop_ok;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign push_ok     = push && !qstat.full;
  assign pop_ok      = pop && !qstat.empty;
  assign out_valid   = !qstat.empty;
  assign out_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_back.sv @@
// Arithmetic pipeline: computes p, q and t and permutes them by sector.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_back import hsv2rgb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  hsv_item_t  in_item,
  output logic       in_ready,
  rgb_if.source      rgb,
  output back_stat_t bstat
);

  localparam int C   = CHANNEL_BITS;
  localparam int H   = HUE_BITS;
  localparam int X_W = 2 * C;
  localparam int P_W = C + H;
  localparam int M_W = 2 * C + H;

  localparam chan_t            CH_MAX  = '1;
  localparam logic [P_W-1:0]   ONE     = {CH_MAX, {H{1'b0}}};
  localparam logic [H:0]       HUE_ONE = {1'b1, {H{1'b0}}};

  // First guess of x / CH_MAX for x below 2^(2C); it is exact or one low.
  function automatic chan_t div_est(input logic [X_W-1:0] x);
    logic [X_W:0] sum;
    sum = {1'b0, x} + (X_W + 1)'(x >> C);
    return sum[X_W-1:C];
  endfunction

  function automatic chan_t div_fix(input logic [X_W-1:0] x, input chan_t est);
    logic [X_W-1:0] rem;
    rem = x - {est, {C{1'b0}}} + X_W'(est);
    return (rem >= X_W'(CH_MAX)) ? est + 1'b1 : est;
  endfunction

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // Stage 1: sat * frac, sat * (1 - frac) and bright * (max - sat).
  logic [H:0]       comp;
  sector_t          sec1;
  logic             gray1;
  chan_t            bright1;
  logic [P_W-1:0]   sf1, sg1;
  logic [X_W-1:0]   pm1;

  // Stage 2: brightness times the q and t terms.
  sector_t          sec2;
  logic             gray2;
  chan_t            bright2;
  logic [M_W-1:0]   qp2, tp2;
  logic [X_W-1:0]   pm2;

  // Stage 3: quotient guesses.
  sector_t          sec3;
  logic             gray3;
  chan_t            bright3;
  logic [X_W-1:0]   xp3, xq3, xt3;
  chan_t            ep3, eq3, et3;

  // Stage 4: output register.
  chan_t            bright4;
  chan_t            p_c, q_c, t_c;
  chan_t            red4, green4, blue4;
  chan_t            red_c, green_c, blue_c;

  assign adv4     = !v4 || rgb.ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign comp = HUE_ONE - {1'b0, in_item.frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sec1    <= in_item.sector;
      gray1   <= in_item.gray;
      bright1 <= in_item.bright;
      sf1     <= P_W'(in_item.sat) * P_W'(in_item.frac);
      sg1     <= P_W'(in_item.sat) * P_W'(comp);
      pm1     <= X_W'(in_item.bright) * X_W'(CH_MAX - in_item.sat);
    end
    if (adv2) begin
      sec2    <= sec1;
      gray2   <= gray1;
      bright2 <= bright1;
      qp2     <= M_W'(bright1) * M_W'(ONE - sf1);
      tp2     <= M_W'(bright1) * M_W'(ONE - sg1);
      pm2     <= pm1;
    end
    if (adv3) begin
      sec3    <= sec2;
      gray3   <= gray2;
      bright3 <= bright2;
      xp3     <= pm2;
      xq3     <= qp2[M_W-1:H];
      xt3     <= tp2[M_W-1:H];
      ep3     <= div_est(pm2);
      eq3     <= div_est(qp2[M_W-1:H]);
      et3     <= div_est(tp2[M_W-1:H]);
    end
    if (adv4) begin
      bright4 <= bright3;
      red4    <= red_c;
      green4  <= green_c;
      blue4   <= blue_c;
    end
  end

  always_comb begin
    p_c = div_fix(xp3, ep3);
    q_c = div_fix(xq3, eq3);
    t_c = div_fix(xt3, et3);
    if (gray3) begin
      red_c   = bright3;
      green_c = bright3;
      blue_c  = bright3;
    end else begin
      unique case (sec3)
        SEC_RED_YELLOW: begin
          red_c = bright3; green_c = t_c; blue_c = p_c;
        end
        SEC_YELLOW_GREEN: begin
          red_c = q_c; green_c = bright3; blue_c = p_c;
        end
        SEC_GREEN_CYAN: begin
          red_c = p_c; green_c = bright3; blue_c = t_c;
        end
        SEC_CYAN_BLUE: begin
          red_c = p_c; green_c = q_c; blue_c = bright3;
        end
        SEC_BLUE_MAGENTA: begin
          red_c = t_c; green_c = p_c; blue_c = bright3;
        end
        default: begin
          red_c = bright3; green_c = p_c; blue_c = q_c;
        end
      endcase
    end
  end

  assign rgb.valid    = v4;
  assign rgb.red      = red4;
  assign rgb.green    = green4;
  assign rgb.blue     = blue4;
  assign bstat.bright = bright4;

endmodule

`default_nettype wire

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: front stage, queue and arithmetic pipeline.
//
// Usage: HSV color requests enter on the hsv channel (hue as a fraction of a
// turn, saturation and brightness as channel codes) and RGB results leave on
// the rgb channel, one result per request, in request order. A request moves
// when valid and ready are both high at a rising clock edge.
// Throughput is one request per cycle; the block takes a new request every
// cycle while results keep flowing. A request passes through the front
// register and the queue, then three arithmetic stages, after which the
// output register presents the result. The two multiplier stages and the
// divide-by-channel-maximum correction set the stage count.
// When the receiver holds rgb.ready low, the arithmetic pipeline fills and
// stops, then the four-entry queue and the front register fill, and only then
// does hsv.ready fall; nothing is dropped and a waiting result holds steady.
// Reset (rst, synchronous, active high) empties the front stage, the queue
// and the pipeline; there is no other state and no configuration.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input logic clk,
  input logic rst,
  hsv_if.sink   hsv,
  rgb_if.source rgb
);

  // Front to queue.
  logic       push;
  hsv_item_t  front_item;
  q_stat_t    qstat;

  // Queue to pipeline.
  logic       q_valid;
  hsv_item_t  q_item;
  logic       back_ready;

  back_stat_t bstat;

  hsv2rgb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .hsv   (hsv),
    .qstat (qstat),
    .push  (push),
    .item  (front_item)
  );

  hsv2rgb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (back_ready),
    .out_valid (q_valid),
    .out_item  (q_item),
    .qstat     (qstat)
  );

  hsv2rgb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_ready (back_ready),
    .rgb      (rgb),
    .bstat    (bstat)
  );

`ifndef NO_ASSERTIONS
  // No channel of a result may exceed the brightness it was made from.
  a_chan_le_bright: assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (rgb.red <= bstat.bright) && (rgb.green <= bstat.bright) &&
                  (rgb.blue <= bstat.bright))
    else $error("result channel above brightness");

  // Every sector permutation places the brightness itself on one channel.
  a_bright_present: assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (rgb.red == bstat.bright) || (rgb.green == bstat.bright) ||
                  (rgb.blue == bstat.bright))
    else $error("brightness missing from result");

  // While the queue has room, the input side must never stall.
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !qstat.full |-> hsv.ready)
    else $error("input stalled with queue space free");
`endif

endmodule

`default_nettype wire
